// File: rtl/atac_pkg.sv
`timescale 1ns / 1ps

package atac_pkg;

    localparam int AXES       = 3;
    localparam int SRCH_STEPS = 7;
    localparam int DEG_RIGHT  = 90;
    localparam int DEG_HALF   = 180;
    localparam int SCALE_W    = 20;
    localparam int K_W        = 7;
    localparam int SQ_W       = 32;
    localparam int LHS_W      = 63;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd3998;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] COS_ONE = 64'd1073578288;
    localparam logic [63:0] SIN_ONE = 64'd18739379;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] x_mg;
        logic signed [15:0] y_mg;
        logic signed [15:0] z_mg;
        logic signed [7:0]  x_tilt_deg;
        logic signed [7:0]  y_tilt_deg;
        logic [7:0]         z_tilt_deg;
        logic               zero_vector;
    } out_item_t;

    typedef logic [30:0] sin2_tab_t [0:DEG_RIGHT];

    // sin^2 of whole degrees in Q1.30, built by rotating a Q30 vector one degree a step.
    function automatic sin2_tab_t build_sin2_tab();
        sin2_tab_t   tab;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] ns;
        logic [63:0] nc;
        logic [63:0] sq;
        s = 64'd0;
        c = Q30_ONE;
        for (int k = 0; k < DEG_RIGHT; k++)
        begin
            sq     = (s * s + (Q30_ONE >> 1)) >> 30;
            tab[k] = sq[30:0];
            ns     = (s * COS_ONE + c * SIN_ONE + (Q30_ONE >> 1)) >> 30;
            nc     = (c * COS_ONE + (Q30_ONE >> 1) - s * SIN_ONE) >> 30;
            s      = ns;
            c      = nc;
        end
        tab[0]         = 31'd0;
        tab[30]        = 31'h1000_0000;
        tab[45]        = 31'h2000_0000;
        tab[60]        = 31'h3000_0000;
        tab[DEG_RIGHT] = 31'h4000_0000;
        return tab;
    endfunction

    localparam sin2_tab_t SIN2_TAB = build_sin2_tab();

    // Scaled magnitude (already shifted down by 16) back to a saturated signed value.
    function automatic logic signed [15:0] sat_mg(input logic neg, input logic [19:0] p);
        logic signed [15:0] r;
        if (neg)
        begin
            if (p > 20'd32768)
                r = 16'sh8000;
            else
                r = 16'(-p[16:0]);
        end
        else
        begin
            if (p > 20'd32767)
                r = 16'sh7fff;
            else
                r = 16'(p);
        end
        return r;
    endfunction

endpackage

// File: rtl/accel_tilt_angle_calc.sv
`timescale 1ns / 1ps
// An accepted item passes stage 0, stage 1, the search stages and then the output register.
// Throughput: one item per cycle while the output is not held; the angle search takes one degree bit per stage
// (seven stages, each with one table lookup, one multiply and compare per axis).
// The whole pipeline holds while a finished result waits to be taken.
// Reset clears all valid bits and sets the scale register to 3998.
module accel_tilt_angle_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [19:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  atac_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output atac_pkg::out_item_t           out_item
);
    import atac_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic               adv;

    // Stage 0: squares and scale products.
    logic               v0_reg;
    logic [SQ_W-1:0]    sq0_reg  [AXES];
    logic [35:0]        mgp0_reg [AXES];
    logic               neg0_reg [AXES];

    // Stage 1: sum of squares and saturated milli-g.
    logic               v1_reg;
    logic [SQ_W-1:0]    sum1_reg;
    logic [SQ_W-1:0]    sq1_reg  [AXES];
    logic signed [15:0] mg1_reg  [AXES];
    logic               neg1_reg [AXES];

    // Search stages.
    logic               vs_reg   [SRCH_STEPS];
    logic [SQ_W-1:0]    sums_reg [SRCH_STEPS];
    logic [SQ_W-1:0]    sqs_reg  [SRCH_STEPS][AXES];
    logic signed [15:0] mgs_reg  [SRCH_STEPS][AXES];
    logic               negs_reg [SRCH_STEPS][AXES];
    logic [K_W-1:0]     ks_reg   [SRCH_STEPS][AXES];
    logic               eqs_reg  [SRCH_STEPS][AXES];
    logic [K_W-1:0]     ks_next  [SRCH_STEPS][AXES];
    logic               eqs_next [SRCH_STEPS][AXES];

    logic               out_vld_reg;
    out_item_t          out_reg;
    out_item_t          out_next;

    logic signed [15:0] raw [AXES];
    logic [15:0]        mag [AXES];

    assign adv       = !out_vld_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    assign raw[0] = in_item.raw_x;
    assign raw[1] = in_item.raw_y;
    assign raw[2] = in_item.raw_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mag[a] = raw[a][15] ? 16'(-raw[a]) : 16'(raw[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_data;
    end

    // Each search stage tries one more bit of the degree count; the table is monotonic.
    always_comb
    begin
        logic [K_W-1:0]   src_k;
        logic             src_eq;
        logic [SQ_W-1:0]  src_sum;
        logic [SQ_W-1:0]  src_sq;
        logic [K_W-1:0]   cand;
        logic [30:0]      tval;
        logic [LHS_W-1:0] lhs;
        logic [LHS_W-1:0] rhs;
        for (int st = 0; st < SRCH_STEPS; st++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (st == 0)
                begin
                    src_k   = '0;
                    src_eq  = 1'b1;
                    src_sum = sum1_reg;
                    src_sq  = sq1_reg[a];
                end
                else
                begin
                    src_k   = ks_reg[st-1][a];
                    src_eq  = eqs_reg[st-1][a];
                    src_sum = sums_reg[st-1];
                    src_sq  = sqs_reg[st-1][a];
                end
                cand = src_k | K_W'(1 << (SRCH_STEPS - 1 - st));
                tval = (cand <= K_W'(DEG_RIGHT)) ? SIN2_TAB[cand] : '0;
                lhs  = LHS_W'(tval) * LHS_W'(src_sum);
                rhs  = LHS_W'({src_sq, 30'd0});
                if (cand <= K_W'(DEG_RIGHT) && lhs <= rhs)
                begin
                    ks_next[st][a]  = cand;
                    eqs_next[st][a] = (lhs == rhs);
                end
                else
                begin
                    ks_next[st][a]  = src_k;
                    eqs_next[st][a] = src_eq;
                end
            end
        end
    end

    always_comb
    begin
        logic [K_W-1:0] kx;
        logic [K_W-1:0] ky;
        logic [K_W-1:0] kz;
        logic           zero;
        kx   = ks_reg[SRCH_STEPS-1][0];
        ky   = ks_reg[SRCH_STEPS-1][1];
        kz   = ks_reg[SRCH_STEPS-1][2];
        zero = (sums_reg[SRCH_STEPS-1] == '0);
        out_next.x_mg = mgs_reg[SRCH_STEPS-1][0];
        out_next.y_mg = mgs_reg[SRCH_STEPS-1][1];
        out_next.z_mg = mgs_reg[SRCH_STEPS-1][2];
        out_next.zero_vector = zero;
        if (zero)
        begin
            out_next.x_tilt_deg = '0;
            out_next.y_tilt_deg = '0;
            out_next.z_tilt_deg = '0;
        end
        else
        begin
            out_next.x_tilt_deg = negs_reg[SRCH_STEPS-1][0] ? -8'(kx) : 8'(kx);
            out_next.y_tilt_deg = negs_reg[SRCH_STEPS-1][1] ? -8'(ky) : 8'(ky);
            if (negs_reg[SRCH_STEPS-1][2])
                out_next.z_tilt_deg = 8'(DEG_RIGHT) + 8'(kz);
            else if (eqs_reg[SRCH_STEPS-1][2])
                out_next.z_tilt_deg = 8'(DEG_RIGHT) - 8'(kz);
            else if (kz == K_W'(DEG_RIGHT))
                out_next.z_tilt_deg = '0;
            else
                out_next.z_tilt_deg = 8'(DEG_RIGHT - 1) - 8'(kz);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int st = 0; st < SRCH_STEPS; st++)
            begin
                vs_reg[st] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            for (int st = 0; st < SRCH_STEPS; st++)
            begin
                vs_reg[st] <= (st == 0) ? v1_reg : vs_reg[st-1];
            end
            out_vld_reg <= vs_reg[SRCH_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sq0_reg[a]  <= SQ_W'(mag[a]) * SQ_W'(mag[a]);
                mgp0_reg[a] <= 36'(mag[a]) * 36'(scale_reg);
                neg0_reg[a] <= raw[a][15];
                sq1_reg[a]  <= sq0_reg[a];
                mg1_reg[a]  <= sat_mg(neg0_reg[a], mgp0_reg[a][35:16]);
                neg1_reg[a] <= neg0_reg[a];
            end
            sum1_reg <= sq0_reg[0] + sq0_reg[1] + sq0_reg[2];
            for (int st = 0; st < SRCH_STEPS; st++)
            begin
                sums_reg[st] <= (st == 0) ? sum1_reg : sums_reg[st-1];
                for (int a = 0; a < AXES; a++)
                begin
                    sqs_reg[st][a]  <= (st == 0) ? sq1_reg[a]  : sqs_reg[st-1][a];
                    mgs_reg[st][a]  <= (st == 0) ? mg1_reg[a]  : mgs_reg[st-1][a];
                    negs_reg[st][a] <= (st == 0) ? neg1_reg[a] : negs_reg[st-1][a];
                    ks_reg[st][a]   <= ks_next[st][a];
                    eqs_reg[st][a]  <= eqs_next[st][a];
                end
            end
            out_reg <= out_next;
        end
    end

    a_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.zero_vector |->
            out_item.x_tilt_deg == 8'sd0 && out_item.y_tilt_deg == 8'sd0 &&
            out_item.z_tilt_deg == 8'd0)
        else $error("zero vector item carries a nonzero angle");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.x_tilt_deg <= 8'sd90 && out_item.x_tilt_deg >= -8'sd90)
        else $error("x tilt outside the right angle");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.z_tilt_deg <= 8'd180)
        else $error("z tilt beyond a half turn");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vs_reg[SRCH_STEPS-1]) && $stable(ks_reg[SRCH_STEPS-1][2]))
        else $error("search pipeline moved during a stall");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import atac_pkg::*;

    localparam int LATENCY   = 10;
    localparam int N_RANDOM  = 1250;
    localparam int MAX_CYCLE = 400000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [19:0]         cfg_data;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_item;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_item;

    accel_tilt_angle_calc u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Directed sample row; chk marks a row whose result is typed in by hand.
    typedef struct {
        logic [19:0] scale;
        in_item_t    smp;
        logic        chk;
        out_item_t   res;
    } vec_row_t;

    logic [31:0] sin_sq_q30 [0:90];
    logic [19:0] scale_q16;
    out_item_t   pending_q [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          stall_phase = 0;
    bit          hand_chk_q [$];
    out_item_t   hand_res_q [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Own rotation table of sin^2 per whole degree, Q2.30.
    task automatic make_sin_sq();
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] ns;
        logic [63:0] nc;
        s = 64'd0;
        c = 64'd1073741824;
        for (int k = 0; k < 90; k++)
        begin
            sin_sq_q30[k] = 32'((s * s + 64'd536870912) >> 30);
            ns = (s * 64'd1073578288 + c * 64'd18739379 + 64'd536870912) >> 30;
            nc = (c * 64'd1073578288 + 64'd536870912 - s * 64'd18739379) >> 30;
            s  = ns;
            c  = nc;
        end
        sin_sq_q30[0]  = 32'd0;
        sin_sq_q30[30] = 32'h1000_0000;
        sin_sq_q30[45] = 32'h2000_0000;
        sin_sq_q30[60] = 32'h3000_0000;
        sin_sq_q30[90] = 32'h4000_0000;
    endtask

    function automatic logic signed [15:0] to_milli_g(logic signed [15:0] raw,
                                                      logic [19:0] scale);
        logic [16:0] m;
        logic [63:0] p;
        m = (raw < 0) ? 17'(-int'(raw)) : 17'(raw);
        p = (64'(m) * 64'(scale)) >> 16;
        if (raw < 0)
            return (p > 64'd32768) ? 16'sh8000 : 16'(-p);
        return (p > 64'd32767) ? 16'sh7fff : 16'(p);
    endfunction

    // Largest whole degree k with sin^2(k) * |v|^2 <= a^2.
    function automatic int floor_asin_deg(logic [63:0] sq, logic [63:0] sum, output bit exact);
        logic [63:0] rhs;
        logic [63:0] lhs;
        int          best;
        rhs   = sq << 30;
        best  = 0;
        exact = 1'b1;
        for (int k = 1; k <= 90; k++)
        begin
            lhs = 64'(sin_sq_q30[k]) * sum;
            if (lhs <= rhs)
            begin
                best  = k;
                exact = (lhs == rhs);
            end
        end
        return best;
    endfunction

    function automatic out_item_t tilt_of(in_item_t smp, logic [19:0] scale);
        out_item_t   r;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] sz;
        logic [63:0] sum;
        int          k;
        int          za;
        bit          ex;
        sx  = 64'(int'(smp.raw_x) * int'(smp.raw_x));
        sy  = 64'(int'(smp.raw_y) * int'(smp.raw_y));
        sz  = 64'(int'(smp.raw_z) * int'(smp.raw_z));
        sum = sx + sy + sz;
        r.x_mg = to_milli_g(smp.raw_x, scale);
        r.y_mg = to_milli_g(smp.raw_y, scale);
        r.z_mg = to_milli_g(smp.raw_z, scale);
        r.x_tilt_deg  = '0;
        r.y_tilt_deg  = '0;
        r.z_tilt_deg  = '0;
        r.zero_vector = (sum == 0);
        if (sum != 0)
        begin
            k = floor_asin_deg(sx, sum, ex);
            r.x_tilt_deg = 8'((smp.raw_x < 0) ? -k : k);
            k = floor_asin_deg(sy, sum, ex);
            r.y_tilt_deg = 8'((smp.raw_y < 0) ? -k : k);
            k = floor_asin_deg(sz, sum, ex);
            if (smp.raw_z < 0)
                za = 90 + k;
            else
                za = ex ? 90 - k : 89 - k;
            if (za < 0)
                za = 0;
            r.z_tilt_deg = 8'(za);
        end
        return r;
    endfunction

    function automatic out_item_t hand_res(int xm, int ym, int zm, int xd, int yd, int zd,
                                           bit zv);
        out_item_t r;
        r.x_mg = 16'(xm);
        r.y_mg = 16'(ym);
        r.z_mg = 16'(zm);
        r.x_tilt_deg  = 8'(xd);
        r.y_tilt_deg  = 8'(yd);
        r.z_tilt_deg  = 8'(zd);
        r.zero_vector = zv;
        return r;
    endfunction

    function automatic in_item_t smp_of(int x, int y, int z);
        in_item_t s;
        s.raw_x = 16'(x);
        s.raw_y = 16'(y);
        s.raw_z = 16'(z);
        return s;
    endfunction

    task automatic write_scale(logic [19:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        scale_q16 = v;
    endtask

    // Holds valid until the item is taken; the gap comes before the item.
    task automatic send_sample(in_item_t smp, int gap, bit chk, out_item_t res);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= smp;
        pending_q.push_back(tilt_of(smp, scale_q16));
        hand_chk_q.push_back(chk);
        hand_res_q.push_back(res);
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic in_item_t rand_sample();
        in_item_t s;
        int       mode;
        int       lim;
        mode = $urandom_range(0, 9);
        lim  = (mode < 3) ? 4 : (mode < 6) ? 300 : 32767;
        s.raw_x = 16'($urandom_range(0, 2 * lim) - lim);
        s.raw_y = 16'($urandom_range(0, 2 * lim) - lim);
        s.raw_z = 16'($urandom_range(0, 2 * lim) - lim);
        if (mode == 9)
            s = 48'({$urandom, $urandom});
        if ($urandom_range(0, 19) == 0)
            s.raw_x = 16'sh8000;
        return s;
    endfunction

    // Receiver: stalls in a slowly changing pattern, with stall-free stretches.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 64) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= (stall_phase % 7 < 3);
            default: out_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        out_item_t exp_res;
        out_item_t got;
        bit        chk;
        out_item_t hres;
        if (rst_n && out_valid && out_ready)
        begin
            got = out_item;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                exp_res = pending_q.pop_front();
                chk     = hand_chk_q.pop_front();
                hres    = hand_res_q.pop_front();
                if (chk && hres != exp_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hand value %h differs from predicted %h", hres, exp_res);
                end
                if (got.x_mg != exp_res.x_mg || got.y_mg != exp_res.y_mg
                    || got.z_mg != exp_res.z_mg || got.x_tilt_deg != exp_res.x_tilt_deg
                    || got.y_tilt_deg != exp_res.y_tilt_deg
                    || got.z_tilt_deg != exp_res.z_tilt_deg
                    || got.zero_vector != exp_res.zero_vector)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", exp_res, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        vec_row_t    rows [$];
        vec_row_t    r;
        out_item_t   none;
        int          burst;
        int          gap;
        logic [19:0] scales [0:4];
        none        = '0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        scale_q16   = 20'd3998;
        make_sin_sq();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: zero vector, pure axes, extremes, equal axes and saturation.
        rows.push_back('{20'd3998, smp_of(0, 0, 0), 1, hand_res(0, 0, 0, 0, 0, 0, 1)});
        rows.push_back('{20'd3998, smp_of(0, 0, 1000), 1, hand_res(0, 0, 61, 0, 0, 0, 0)});
        rows.push_back('{20'd3998, smp_of(0, 0, -1), 1, hand_res(0, 0, 0, 0, 0, 180, 0)});
        rows.push_back('{20'd3998, smp_of(1, 0, 0), 1, hand_res(0, 0, 0, 90, 0, 90, 0)});
        rows.push_back('{20'd3998, smp_of(0, -1, 0), 1, hand_res(0, 0, 0, 0, -90, 90, 0)});
        rows.push_back('{20'd3998, smp_of(-32768, 0, 0), 0, none});
        rows.push_back('{20'd3998, smp_of(32767, 32767, 32767), 0, none});
        rows.push_back('{20'd3998, smp_of(-32768, -32768, -32768), 0, none});
        rows.push_back('{20'd3998, smp_of(100, 0, 100), 0, none});
        rows.push_back('{20'd3998, smp_of(1, 1, 0), 0, none});
        rows.push_back('{20'd65536, smp_of(-32768, 32767, 5), 1,
                         hand_res(-32768, 32767, 5, -45, 44, 90, 0)});
        rows.push_back('{20'hfffff, smp_of(32767, -32768, 0), 1,
                         hand_res(32767, -32768, 0, 44, -45, 90, 0)});
        rows.push_back('{20'hfffff, smp_of(2, -3, 1), 0, none});
        rows.push_back('{20'd0, smp_of(32767, -32768, 12345), 0, none});
        rows.push_back('{20'd1, smp_of(-1, 1, 0), 0, none});
        rows.push_back('{20'd3998, smp_of(0, 0, 0), 1, hand_res(0, 0, 0, 0, 0, 0, 1)});

        foreach (rows[i])
        begin
            r = rows[i];
            if (r.scale != scale_q16)
            begin
                drain();
                write_scale(r.scale);
            end
            send_sample(r.smp, $urandom_range(0, 2), r.chk, r.res);
        end

        scales[0] = 20'd0;
        scales[1] = 20'hfffff;
        scales[2] = 20'd3998;
        scales[3] = 20'd65536;
        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_scale((ph < 4) ? scales[ph] : 20'($urandom_range(0, 20'hfffff)));
            for (int n = 0; n < N_RANDOM / 5; )
            begin
                burst = $urandom_range(1, 40);
                gap   = $urandom_range(0, 6);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++)
                    send_sample(rand_sample(), (b == 0) ? gap : 0, 0, none);
            end
        end
        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: accel_tilt_angle_calc.f
rtl/atac_pkg.sv
rtl/accel_tilt_angle_calc.sv
sim/tb.sv
